// ----- hw/rtl/brl_pkg.sv -----
// Shared types and constants for the Bresenham line rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package brl_pkg;

  // Item kinds carried in the action field.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // Depth of the queue between front and back.
  localparam int unsigned Q_DEPTH = 4;

  // Queue status seen by both ends.
  typedef struct packed {
    logic can_push;   // a slot is free
    logic has_item;   // head entry is valid
  } q_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/brl_front.sv -----
// Front end: accepts items and precomputes line setup for loads.
`timescale 1ns / 1ps
`default_nettype none

module brl_front
  import brl_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  localparam int unsigned EW = 4 * COORD_BITS + 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_action,
  input  wire logic [COORD_BITS-1:0] in_start_x,
  input  wire logic [COORD_BITS-1:0] in_start_y,
  input  wire logic [COORD_BITS-1:0] in_end_x,
  input  wire logic [COORD_BITS-1:0] in_end_y,
  input  wire q_status_t             q_status,
  output logic                       q_push,
  output logic [EW-1:0]              q_data
);

  logic                  dir_x_neg;
  logic                  dir_y_neg;
  logic                  steep;
  logic [COORD_BITS-1:0] abs_dx;
  logic [COORD_BITS-1:0] abs_dy;
  logic                  is_step;

  // Stall only on a full queue
  assign in_stall = !q_status.can_push;
  assign q_push   = in_valid && q_status.can_push;

  // Directions, distances and octant class of a load
  always_comb begin
    dir_x_neg = in_end_x < in_start_x;
    dir_y_neg = in_end_y < in_start_y;
    abs_dx    = dir_x_neg ? (in_start_x - in_end_x) : (in_end_x - in_start_x);
    abs_dy    = dir_y_neg ? (in_start_y - in_end_y) : (in_end_y - in_start_y);
    steep     = abs_dy > abs_dx;
    is_step   = (in_action == ACT_STEP);
  end

  // Entry layout: kind, start, distances, directions, steep
  assign q_data = {is_step, in_start_x, in_start_y, abs_dx, abs_dy,
                   dir_x_neg, dir_y_neg, steep};

  // rst_n and clk only matter for the checks below
  property p_push_means_room;
    @(posedge clk) disable iff (!rst_n)
      q_push |-> q_status.can_push;
  endproperty
  a_push_means_room: assert property (p_push_means_room)
    else $error("front pushed into a full queue");

  property p_load_dist_order;
    @(posedge clk) disable iff (!rst_n)
      (q_push && !is_step) |-> (steep ? (abs_dy > abs_dx) : (abs_dx >= abs_dy));
  endproperty
  a_load_dist_order: assert property (p_load_dist_order)
    else $error("octant class disagrees with distances");

  property p_stall_tracks_queue;
    @(posedge clk) disable iff (!rst_n)
      q_status.has_item && !q_status.can_push |-> in_stall;
  endproperty
  a_stall_tracks_queue: assert property (p_stall_tracks_queue)
    else $error("input not stalled on full queue");

endmodule

`default_nettype wire

// ----- hw/rtl/brl_queue.sv -----
// Short register queue between front and back.
`timescale 1ns / 1ps
`default_nettype none

module brl_queue
  import brl_pkg::*;
#(
  parameter int unsigned WIDTH = 52
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head_data,
  output q_status_t             status
);

  localparam int unsigned PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CW = $clog2(Q_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(Q_DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(Q_DEPTH - 1);

  logic [WIDTH-1:0] slot_r [Q_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign status.can_push = cnt_r != FULL_CNT;
  assign status.has_item = cnt_r != '0;
  assign head_data       = slot_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("queue count over depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> status.has_item)
    else $error("pop from empty queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointer gap");

endmodule

`default_nettype wire

// ----- hw/rtl/brl_back.sv -----
// Back end: line state, Bresenham step and output register.
`timescale 1ns / 1ps
`default_nettype none

module brl_back
  import brl_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  localparam int unsigned EW = 4 * COORD_BITS + 4,
  localparam int unsigned DW = COORD_BITS + 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [23:0]           cfg_wdata,
  input  wire q_status_t             q_status,
  input  wire logic [EW-1:0]         q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [COORD_BITS-1:0]      out_pixel_x,
  output logic [COORD_BITS-1:0]      out_pixel_y,
  output logic [23:0]                out_pixel_color,
  output logic                       out_last_pixel
);

  localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

  // Unpacked head entry
  logic                  h_step;
  logic [COORD_BITS-1:0] h_sx, h_sy, h_adx, h_ady;
  logic                  h_dxn, h_dyn, h_steep;

  assign {h_step, h_sx, h_sy, h_adx, h_ady, h_dxn, h_dyn, h_steep} = q_head;

  // Line state
  logic [COORD_BITS-1:0]  pos_x_r, pos_x_nxt;
  logic [COORD_BITS-1:0]  pos_y_r, pos_y_nxt;
  logic [COORD_BITS-1:0]  remaining_r, remaining_nxt;
  logic [COORD_BITS-1:0]  major_r, major_nxt;
  logic [COORD_BITS-1:0]  minor_r, minor_nxt;
  logic signed [DW-1:0]   decision_r, decision_nxt;
  logic                   dir_x_neg_r, dir_x_neg_nxt;
  logic                   dir_y_neg_r, dir_y_neg_nxt;
  logic                   steep_r, steep_nxt;
  logic                   busy_r, busy_nxt;
  logic [23:0]            color_r;

  // Output register
  logic                   out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0]  out_x_r, out_y_r;
  logic [23:0]            out_color_r;
  logic                   out_last_r;

  logic                   emit;
  logic [COORD_BITS-1:0]  ld_major, ld_minor;
  logic signed [DW-1:0]   d_diag, d_straight;

  assign q_pop = q_status.has_item && (!out_valid_r || !out_stall);

  // Execute the head item
  always_comb begin
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    remaining_nxt = remaining_r;
    major_nxt     = major_r;
    minor_nxt     = minor_r;
    decision_nxt  = decision_r;
    dir_x_neg_nxt = dir_x_neg_r;
    dir_y_neg_nxt = dir_y_neg_r;
    steep_nxt     = steep_r;
    busy_nxt      = busy_r;
    emit          = 1'b0;

    ld_major   = h_steep ? h_ady : h_adx;
    ld_minor   = h_steep ? h_adx : h_ady;
    d_diag     = $signed({1'b0, minor_r, 1'b0}) - $signed({1'b0, major_r, 1'b0});
    d_straight = $signed({1'b0, minor_r, 1'b0});

    if (q_pop) begin
      if (!h_step) begin
        // Load: latch start point, distances and directions, and start the decision term
        pos_x_nxt     = h_sx;
        pos_y_nxt     = h_sy;
        major_nxt     = ld_major;
        minor_nxt     = ld_minor;
        remaining_nxt = ld_major;
        decision_nxt  = $signed({1'b0, ld_minor, 1'b0}) - $signed({2'b00, ld_major});
        dir_x_neg_nxt = h_dxn;
        dir_y_neg_nxt = h_dyn;
        steep_nxt     = h_steep;
        busy_nxt      = ld_major != '0;
        emit          = 1'b1;
      end else if (busy_r) begin
        // Step: diagonal on a tie or positive term
        if (decision_r >= 0) begin
          pos_x_nxt    = dir_x_neg_r ? pos_x_r - ONE : pos_x_r + ONE;
          pos_y_nxt    = dir_y_neg_r ? pos_y_r - ONE : pos_y_r + ONE;
          decision_nxt = decision_r + d_diag;
        end else begin
          if (steep_r) begin
            pos_y_nxt = dir_y_neg_r ? pos_y_r - ONE : pos_y_r + ONE;
          end else begin
            pos_x_nxt = dir_x_neg_r ? pos_x_r - ONE : pos_x_r + ONE;
          end
          decision_nxt = decision_r + d_straight;
        end
        remaining_nxt = remaining_r - ONE;
        busy_nxt      = remaining_r != ONE;
        emit          = 1'b1;
      end
    end

    // Output valid: load on emit, clear when taken
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_stall) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      remaining_r <= '0;
      major_r     <= '0;
      minor_r     <= '0;
      decision_r  <= '0;
      dir_x_neg_r <= 1'b0;
      dir_y_neg_r <= 1'b0;
      steep_r     <= 1'b0;
      busy_r      <= 1'b0;
      color_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      remaining_r <= remaining_nxt;
      major_r     <= major_nxt;
      minor_r     <= minor_nxt;
      decision_r  <= decision_nxt;
      dir_x_neg_r <= dir_x_neg_nxt;
      dir_y_neg_r <= dir_y_neg_nxt;
      steep_r     <= steep_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        color_r <= cfg_wdata;
      end
    end
  end

  // Output payload, no reset
  always_ff @(posedge clk) begin
    if (emit) begin
      out_x_r     <= pos_x_nxt;
      out_y_r     <= pos_y_nxt;
      out_color_r <= color_r;
      out_last_r  <= !busy_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_color = out_color_r;
  assign out_last_pixel  = out_last_r;

  a_busy_remaining: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (remaining_r != '0 && remaining_r <= major_r))
    else $error("active line with bad remaining count");

  a_axis_order: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (major_r >= minor_r))
    else $error("minor distance exceeds major");

  a_idle_step_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && h_step && !busy_r) |=> !out_valid_r)
    else $error("step with no active line produced a pixel");

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (out_last_r == !busy_r))
    else $error("last flag disagrees with line state");

endmodule

`default_nettype wire

// ----- hw/rtl/bresenham_line_rasterizer.sv -----
// Top level of the Bresenham line rasterizer: front, queue and back.
// Path: an accepted item is written into the queue, then the back end pops it and registers its pixel.
// Throughput: one item per cycle when not stalled; each step is one add and compare.
// A four-entry queue lets input and output stall independently.
// Reset (rst_n low, synchronous) clears line state, queue, color and out_valid.
// Output payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module bresenham_line_rasterizer
  import brl_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [23:0]           cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_action,
  input  wire logic [COORD_BITS-1:0] in_start_x,
  input  wire logic [COORD_BITS-1:0] in_start_y,
  input  wire logic [COORD_BITS-1:0] in_end_x,
  input  wire logic [COORD_BITS-1:0] in_end_y,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [COORD_BITS-1:0]      out_pixel_x,
  output logic [COORD_BITS-1:0]      out_pixel_y,
  output logic [23:0]                out_pixel_color,
  output logic                       out_last_pixel
);

  localparam int unsigned EW = 4 * COORD_BITS + 4;

  q_status_t      q_status;
  logic           q_push;
  logic           q_pop;
  logic [EW-1:0]  q_in_data;
  logic [EW-1:0]  q_head;

  brl_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_action  (in_action),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .q_status   (q_status),
    .q_push     (q_push),
    .q_data     (q_in_data)
  );

  brl_queue #(.WIDTH(EW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in_data),
    .pop       (q_pop),
    .head_data (q_head),
    .status    (q_status)
  );

  brl_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .q_status        (q_status),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_last_pixel  (out_last_pixel)
  );

endmodule

`default_nettype wire
